@@ hdl/jsu_pkg.sv @@
// Package for the JSON string unescaper: shared types and constants.
// Used by jsu_step, json_string_unescaper_core, the checker and the testbench; depends on nothing.
`default_nettype none

package jsu_pkg;

  // Decoder phase, one-hot.
  typedef enum logic [5:0] {
    PH_PLAIN   = 6'b000001,
    PH_ESC     = 6'b000010,
    PH_HEX1    = 6'b000100,
    PH_WANT_BS = 6'b001000,
    PH_WANT_U  = 6'b010000,
    PH_HEX2    = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_END     = 3'd1,
    KIND_BADHEX  = 3'd2,
    KIND_BADSUR  = 3'd3,
    KIND_BADCP   = 3'd4,
    KIND_NOQUOTE = 3'd5
  } kind_e;

  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  digit_count;
    logic [15:0] first_unit;
    logic [15:0] second_unit;
  } state_t;

  localparam state_t StateReset = '{
    phase:       PH_PLAIN,
    digit_count: 2'd0,
    first_unit:  16'h0000,
    second_unit: 16'h0000
  };

  // Results of one input byte. Every result before the last one is data;
  // the last one carries kind.
  typedef struct packed {
    logic [2:0]       count;
    logic [3:0][7:0]  bytes;
    kind_e            kind;
  } step_res_t;

  localparam logic [7:0] ChrNul   = 8'h00;
  localparam logic [7:0] ChrQuote = 8'h22;
  localparam logic [7:0] ChrSlash = 8'h2F;
  localparam logic [7:0] ChrBslash = 8'h5C;
  localparam logic [7:0] ChrB     = 8'h62;
  localparam logic [7:0] ChrF     = 8'h66;
  localparam logic [7:0] ChrN     = 8'h6E;
  localparam logic [7:0] ChrR     = 8'h72;
  localparam logic [7:0] ChrT     = 8'h74;
  localparam logic [7:0] ChrU     = 8'h75;

endpackage

`default_nettype wire

@@ hdl/jsu_step.sv @@
// Combinational next-state and result logic for one string byte.
// Depends on jsu_pkg.
`default_nettype none

module jsu_step (
  input  var jsu_pkg::state_t    cur_i,
  input  wire logic [7:0]        byte_i,
  output var jsu_pkg::state_t    nxt_o,
  output var jsu_pkg::step_res_t res_o
);

  // Bit 4 is set for a valid hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic jsu_pkg::step_res_t utf8(input logic [20:0] cp);
    jsu_pkg::step_res_t r;
    r.count = 3'd0;
    r.bytes = '0;
    r.kind  = jsu_pkg::KIND_DATA;
    if (cp < 21'h80) begin
      r.count    = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.count    = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp[20:11] == 10'b0000011011) begin
      // Codepoint in the surrogate range D800..DFFF.
      r.count = 3'd1;
      r.kind  = jsu_pkg::KIND_BADCP;
    end else if (cp < 21'h10000) begin
      r.count    = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else if (cp < 21'h110000) begin
      r.count    = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end else begin
      r.count = 3'd1;
      r.kind  = jsu_pkg::KIND_BADCP;
    end
    return r;
  endfunction

  logic [4:0]  hex;
  logic [15:0] unit1;
  logic [15:0] unit2;
  logic [20:0] pair_cp;

  assign hex     = hex_digit(byte_i);
  assign unit1   = {cur_i.first_unit[11:0], hex[3:0]};
  assign unit2   = {cur_i.second_unit[11:0], hex[3:0]};
  // High unit is 110110xx_xxxxxxxx and low unit 110111xx_xxxxxxxx here.
  assign pair_cp = 21'h10000 + {1'b0, cur_i.first_unit[9:0], unit2[9:0]};

  always_comb begin
    nxt_o       = cur_i;
    res_o.count = 3'd0;
    res_o.bytes = '0;
    res_o.kind  = jsu_pkg::KIND_DATA;
    case (cur_i.phase)
      jsu_pkg::PH_ESC: begin
        nxt_o.phase = jsu_pkg::PH_PLAIN;
        case (byte_i)
          jsu_pkg::ChrBslash, jsu_pkg::ChrSlash, jsu_pkg::ChrQuote: begin
            res_o.count    = 3'd1;
            res_o.bytes[0] = byte_i;
          end
          jsu_pkg::ChrB: begin
            res_o.count    = 3'd1;
            res_o.bytes[0] = 8'h08;
          end
          jsu_pkg::ChrF: begin
            res_o.count    = 3'd1;
            res_o.bytes[0] = 8'h0C;
          end
          jsu_pkg::ChrN: begin
            res_o.count    = 3'd1;
            res_o.bytes[0] = 8'h0A;
          end
          jsu_pkg::ChrR: begin
            res_o.count    = 3'd1;
            res_o.bytes[0] = 8'h0D;
          end
          jsu_pkg::ChrT: begin
            res_o.count    = 3'd1;
            res_o.bytes[0] = 8'h09;
          end
          jsu_pkg::ChrU: begin
            nxt_o.phase       = jsu_pkg::PH_HEX1;
            nxt_o.digit_count = 2'd0;
            nxt_o.first_unit  = 16'h0000;
          end
          default: begin
            // Unknown escape: the backslash goes out, then the byte is
            // treated as plain text. A backslash cannot reach this arm.
            res_o.bytes[0] = jsu_pkg::ChrBslash;
            res_o.count    = 3'd2;
            if (byte_i == jsu_pkg::ChrNul) begin
              res_o.kind = jsu_pkg::KIND_NOQUOTE;
              nxt_o      = jsu_pkg::StateReset;
            end else if (byte_i == jsu_pkg::ChrQuote) begin
              res_o.kind = jsu_pkg::KIND_END;
              nxt_o      = jsu_pkg::StateReset;
            end else begin
              res_o.bytes[1] = byte_i;
            end
          end
        endcase
      end
      jsu_pkg::PH_HEX1: begin
        if (!hex[4]) begin
          res_o.count = 3'd1;
          res_o.kind  = jsu_pkg::KIND_BADHEX;
          nxt_o       = jsu_pkg::StateReset;
        end else if (cur_i.digit_count != 2'd3) begin
          nxt_o.first_unit  = unit1;
          nxt_o.digit_count = cur_i.digit_count + 2'd1;
        end else if (unit1[15:10] == 6'b110110) begin
          nxt_o.first_unit  = unit1;
          nxt_o.digit_count = 2'd0;
          nxt_o.phase       = jsu_pkg::PH_WANT_BS;
        end else begin
          res_o = utf8({5'd0, unit1});
          nxt_o = jsu_pkg::StateReset;
        end
      end
      jsu_pkg::PH_WANT_BS: begin
        if (byte_i != jsu_pkg::ChrBslash) begin
          res_o.count = 3'd1;
          res_o.kind  = jsu_pkg::KIND_BADSUR;
          nxt_o       = jsu_pkg::StateReset;
        end else begin
          nxt_o.phase = jsu_pkg::PH_WANT_U;
        end
      end
      jsu_pkg::PH_WANT_U: begin
        if (byte_i != jsu_pkg::ChrU) begin
          res_o.count = 3'd1;
          res_o.kind  = jsu_pkg::KIND_BADSUR;
          nxt_o       = jsu_pkg::StateReset;
        end else begin
          nxt_o.phase       = jsu_pkg::PH_HEX2;
          nxt_o.digit_count = 2'd0;
          nxt_o.second_unit = 16'h0000;
        end
      end
      jsu_pkg::PH_HEX2: begin
        if (!hex[4]) begin
          res_o.count = 3'd1;
          res_o.kind  = jsu_pkg::KIND_BADSUR;
          nxt_o       = jsu_pkg::StateReset;
        end else if (cur_i.digit_count != 2'd3) begin
          nxt_o.second_unit = unit2;
          nxt_o.digit_count = cur_i.digit_count + 2'd1;
        end else if (unit2[15:10] != 6'b110111) begin
          res_o.count = 3'd1;
          res_o.kind  = jsu_pkg::KIND_BADSUR;
          nxt_o       = jsu_pkg::StateReset;
        end else begin
          res_o = utf8(pair_cp);
          nxt_o = jsu_pkg::StateReset;
        end
      end
      default: begin
        nxt_o.phase = jsu_pkg::PH_PLAIN;
        if (byte_i == jsu_pkg::ChrNul) begin
          res_o.count = 3'd1;
          res_o.kind  = jsu_pkg::KIND_NOQUOTE;
          nxt_o       = jsu_pkg::StateReset;
        end else if (byte_i == jsu_pkg::ChrQuote) begin
          res_o.count = 3'd1;
          res_o.kind  = jsu_pkg::KIND_END;
          nxt_o       = jsu_pkg::StateReset;
        end else if (byte_i == jsu_pkg::ChrBslash) begin
          nxt_o.phase = jsu_pkg::PH_ESC;
        end else begin
          res_o.count    = 3'd1;
          res_o.bytes[0] = byte_i;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/json_string_unescaper_core.sv @@
// Top level of the JSON string unescaper: decoder state and result buffer.
// Depends on jsu_pkg and jsu_step.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+----------------------------------
//   in      | input     | in_valid_i / in_stall_o  | in_byte_i
//   out     | output    | out_valid_o / out_stall_i| out_byte_o, out_kind_o, out_last_o
//
// An accepted byte is decoded in the same cycle and its 0 to 4 results are
// loaded into the result buffer; the first is offered in the next cycle.
// A byte that yields one result lets the next byte in every cycle unless the
// output stalls. A byte with more results holds the input while the buffer
// drains until its last result leaves, and an output stall holds it further.
// Reset returns the decoder to plain text with an empty buffer.
`default_nettype none

module json_string_unescaper_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output var  logic       in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output var  logic       out_valid_o,
  input  wire logic       out_stall_i,
  output var  logic [7:0] out_byte_o,
  output var  logic [2:0] out_kind_o,
  output var  logic       out_last_o
);

  jsu_pkg::state_t    state_q, state_d;
  jsu_pkg::step_res_t step_res;

  logic [2:0]      res_cnt_q, res_cnt_d;
  logic [3:0][7:0] res_byte_q, res_byte_d;
  jsu_pkg::kind_e  res_kind_q, res_kind_d;

  logic in_acc;
  logic out_pop;

  jsu_step u_step (
    .cur_i  (state_q),
    .byte_i (in_byte_i),
    .nxt_o  (state_d),
    .res_o  (step_res)
  );

  assign out_valid_o = (res_cnt_q != 3'd0);
  assign out_last_o  = (res_cnt_q == 3'd1);
  assign out_byte_o  = res_byte_q[0];
  assign out_kind_o  = out_last_o ? res_kind_q : jsu_pkg::KIND_DATA;
  assign out_pop     = out_valid_o && !out_stall_i;

  // A new byte may enter when the buffer is empty or its last result leaves now.
  assign in_stall_o = (res_cnt_q > 3'd1) || (out_last_o && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    res_cnt_d  = res_cnt_q;
    res_byte_d = res_byte_q;
    res_kind_d = res_kind_q;
    if (in_acc) begin
      res_cnt_d  = step_res.count;
      res_byte_d = step_res.bytes;
      res_kind_d = step_res.kind;
    end else if (out_pop) begin
      res_cnt_d  = res_cnt_q - 3'd1;
      res_byte_d = {8'h00, res_byte_q[3:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= jsu_pkg::StateReset;
      res_cnt_q <= 3'd0;
    end else begin
      if (in_acc) state_q <= state_d;
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_byte_q <= res_byte_d;
    res_kind_q <= res_kind_d;
  end

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q <= 3'(jsu_pkg::MaxResults))
    else $error("result count above maximum");

  a_accept_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (res_cnt_q == 3'd0) || (res_cnt_q == 3'd1 && !out_stall_i))
    else $error("byte accepted while results were still pending");

  a_results_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && step_res.count != 3'd0 |=> out_valid_o && out_byte_o == $past(step_res.bytes[0]))
    else $error("results of an accepted byte did not appear");

  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != jsu_pkg::KIND_DATA |-> out_last_o && out_byte_o == 8'h00)
    else $error("status result is not a final zero-byte transaction");

endmodule

`default_nettype wire

@@ verif/json_string_unescaper_checker.sv @@
// Checker for json_string_unescaper_core: watches both channels, predicts the
// decoded results of every accepted byte and compares them in order.
// Depends on jsu_pkg for the phase and result kind codes.
`default_nettype none

module json_string_unescaper_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] out_byte_i,
  input  wire logic [2:0] out_kind_i,
  input  wire logic       out_last_i,
  output var  int         errors_o,
  output var  int         pending_o
);

  typedef struct packed {
    logic [7:0]     data;
    jsu_pkg::kind_e kind;
    logic           last;
  } result_t;

  result_t         decoded_q[$];
  result_t         step_q[$];
  jsu_pkg::phase_e phase;
  logic [1:0]      digit_cnt;
  logic [15:0]     high_unit;
  logic [15:0]     low_unit;

  task automatic clear_state();
    phase     = jsu_pkg::PH_PLAIN;
    digit_cnt = 2'd0;
    high_unit = 16'h0000;
    low_unit  = 16'h0000;
  endtask

  task automatic emit(input logic [7:0] b, input jsu_pkg::kind_e k);
    result_t r;
    r.data = b;
    r.kind = k;
    r.last = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic raise_error(input jsu_pkg::kind_e k);
    clear_state();
    emit(8'h00, k);
  endtask

  task automatic take_plain(input logic [7:0] c);
    if (c == jsu_pkg::ChrNul) raise_error(jsu_pkg::KIND_NOQUOTE);
    else if (c == jsu_pkg::ChrQuote) raise_error(jsu_pkg::KIND_END);
    else if (c == jsu_pkg::ChrBslash) phase = jsu_pkg::PH_ESC;
    else emit(c, jsu_pkg::KIND_DATA);
  endtask

  task automatic encode_utf8(input int unsigned cp);
    if (cp < 'h80) begin
      emit(8'(cp), jsu_pkg::KIND_DATA);
    end else if (cp < 'h800) begin
      emit(8'(192 + (cp >> 6)), jsu_pkg::KIND_DATA);
      emit(8'('h80 + (cp & 63)), jsu_pkg::KIND_DATA);
    end else if (cp >= 'hd800 && cp < 'he000) begin
      raise_error(jsu_pkg::KIND_BADCP);
      return;
    end else if (cp < 'h10000) begin
      emit(8'(224 + (cp >> 12)), jsu_pkg::KIND_DATA);
      emit(8'('h80 + ((cp >> 6) & 63)), jsu_pkg::KIND_DATA);
      emit(8'('h80 + (cp & 63)), jsu_pkg::KIND_DATA);
    end else if (cp < 'h110000) begin
      emit(8'(240 + (cp >> 18)), jsu_pkg::KIND_DATA);
      emit(8'('h80 + ((cp >> 12) & 63)), jsu_pkg::KIND_DATA);
      emit(8'('h80 + ((cp >> 6) & 63)), jsu_pkg::KIND_DATA);
      emit(8'('h80 + (cp & 63)), jsu_pkg::KIND_DATA);
    end else begin
      raise_error(jsu_pkg::KIND_BADCP);
      return;
    end
    clear_state();
  endtask

  // Advances the decoder by one byte and queues the results it causes.
  task automatic decode_byte(input logic [7:0] c);
    int      h;
    result_t r;
    step_q.delete();
    if (c >= 8'h30 && c <= 8'h39) h = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) h = c - 8'h61 + 10;
    else if (c >= 8'h41 && c <= 8'h46) h = c - 8'h41 + 10;
    else h = -1;

    case (phase)
      jsu_pkg::PH_ESC: begin
        phase = jsu_pkg::PH_PLAIN;
        case (c)
          jsu_pkg::ChrBslash, jsu_pkg::ChrSlash, jsu_pkg::ChrQuote:
            emit(c, jsu_pkg::KIND_DATA);
          jsu_pkg::ChrB: emit(8'h08, jsu_pkg::KIND_DATA);
          jsu_pkg::ChrF: emit(8'h0c, jsu_pkg::KIND_DATA);
          jsu_pkg::ChrN: emit(8'h0a, jsu_pkg::KIND_DATA);
          jsu_pkg::ChrR: emit(8'h0d, jsu_pkg::KIND_DATA);
          jsu_pkg::ChrT: emit(8'h09, jsu_pkg::KIND_DATA);
          jsu_pkg::ChrU: begin
            phase     = jsu_pkg::PH_HEX1;
            digit_cnt = 2'd0;
            high_unit = 16'h0000;
          end
          default: begin
            // An unknown escape keeps its backslash; the byte is then plain text.
            emit(jsu_pkg::ChrBslash, jsu_pkg::KIND_DATA);
            take_plain(c);
          end
        endcase
      end
      jsu_pkg::PH_HEX1: begin
        if (h < 0) begin
          raise_error(jsu_pkg::KIND_BADHEX);
        end else begin
          high_unit = {high_unit[11:0], 4'(h)};
          if (digit_cnt != 2'd3) begin
            digit_cnt++;
          end else begin
            digit_cnt = 2'd0;
            if ((high_unit & 16'hfc00) == 16'hd800) phase = jsu_pkg::PH_WANT_BS;
            else encode_utf8(32'(high_unit));
          end
        end
      end
      jsu_pkg::PH_WANT_BS: begin
        if (c != jsu_pkg::ChrBslash) raise_error(jsu_pkg::KIND_BADSUR);
        else phase = jsu_pkg::PH_WANT_U;
      end
      jsu_pkg::PH_WANT_U: begin
        if (c != jsu_pkg::ChrU) begin
          raise_error(jsu_pkg::KIND_BADSUR);
        end else begin
          phase     = jsu_pkg::PH_HEX2;
          digit_cnt = 2'd0;
          low_unit  = 16'h0000;
        end
      end
      jsu_pkg::PH_HEX2: begin
        if (h < 0) begin
          raise_error(jsu_pkg::KIND_BADSUR);
        end else begin
          low_unit = {low_unit[11:0], 4'(h)};
          if (digit_cnt != 2'd3) begin
            digit_cnt++;
          end else begin
            digit_cnt = 2'd0;
            if ((low_unit & 16'hfc00) != 16'hdc00) raise_error(jsu_pkg::KIND_BADSUR);
            else encode_utf8(32'h10000 + ((32'(high_unit) - 32'hd800) << 10)
                             + (32'(low_unit) - 32'hdc00));
          end
        end
      end
      default: begin
        phase = jsu_pkg::PH_PLAIN;
        take_plain(c);
      end
    endcase

    for (int i = 0; i < step_q.size(); i++) begin
      r      = step_q[i];
      r.last = (i == step_q.size() - 1);
      decoded_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string field, input int expv, input int actv);
    errors_o++;
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, expv, actv);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_state();
      decoded_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) decode_byte(in_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected transaction: expected none, %s %0h kind %0d last %0b",
                   $time, "actual byte", out_byte_i, out_kind_i, out_last_i);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_i !== want.data) report_mismatch("out_byte", want.data, out_byte_i);
          if (out_kind_i !== want.kind) report_mismatch("out_kind", want.kind, out_kind_i);
          if (out_last_i !== want.last) report_mismatch("out_last", want.last, out_last_i);
        end
      end
      pending_o = decoded_q.size();
    end
  end

endmodule

`default_nettype wire

@@ verif/json_string_unescaper_core_tb.sv @@
// Testbench top for json_string_unescaper_core: feeds directed and random
// JSON string bodies with random idling and gives the verdict.
// Depends on jsu_pkg, the core and json_string_unescaper_checker.
`default_nettype none

module json_string_unescaper_core_tb;

  localparam int RandomItems = 170;

  logic       clk       = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       out_stall = 1'b0;
  wire logic       in_stall;
  wire logic       out_valid;
  wire logic [7:0] out_byte;
  wire logic [2:0] out_kind;
  wire logic       out_last;
  int   errors;
  int   pending;
  int   bytes_sent = 0;
  logic calm = 1'b0;
  logic [7:0] esc_chars [8] = '{jsu_pkg::ChrBslash, jsu_pkg::ChrSlash, jsu_pkg::ChrQuote,
                                jsu_pkg::ChrB, jsu_pkg::ChrF, jsu_pkg::ChrN,
                                jsu_pkg::ChrR, jsu_pkg::ChrT};

  json_string_unescaper_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .out_kind_o  (out_kind),
    .out_last_o  (out_last)
  );

  json_string_unescaper_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_byte_i  (out_byte),
    .out_kind_i  (out_kind),
    .out_last_i  (out_last),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // Zero now and then, otherwise any byte but the one given.
  function automatic logic [7:0] random_except(input logic [7:0] x);
    logic [7:0] r;
    if ($urandom_range(0, 3) == 0) return jsu_pkg::ChrNul;
    do r = 8'($urandom_range(1, 255)); while (r == x);
    return r;
  endfunction

  function automatic logic [7:0] bad_digit();
    logic [7:0] r;
    if ($urandom_range(0, 3) == 0) return jsu_pkg::ChrNul;
    do r = 8'($urandom_range(1, 255));
    while (r inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Sends \u and the leading hex digits of a code unit, in mixed letter case.
  task automatic send_hex(input logic [15:0] u, input int digits);
    logic [3:0] v;
    send_byte(jsu_pkg::ChrBslash);
    send_byte(jsu_pkg::ChrU);
    for (int i = 3; i > 3 - digits; i--) begin
      v = u[i*4 +: 4];
      if (v < 4'd10) send_byte(8'h30 + 8'(v));
      else send_byte(($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10);
    end
  endtask

  task automatic send_codepoint(input int unsigned cp);
    logic [19:0] v;
    if (cp >= 'h10000) begin
      v = 20'(cp - 'h10000);
      send_hex(16'hd800 | 16'(v[19:10]), 4);
      send_hex(16'hdc00 | 16'(v[9:0]), 4);
    end else begin
      send_hex(16'(cp), 4);
    end
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int n;
    forever begin
      n = draw_wait();
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin
    logic [7:0]  b;
    logic [15:0] u;
    int unsigned cp;
    int          start;

    repeat (11) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Byte extremes, every simple escape, an unknown escape and a string end.
    send_byte(8'h01);
    send_byte(8'hff);
    send_byte(8'h7f);
    send_byte(8'h80);
    send_text("\\\\\\/\\\"\\b\\f\\n\\r\\t\\q\"");
    // Boundaries of every UTF-8 length, including a null escape.
    send_codepoint(0);
    send_codepoint('h7f);
    send_codepoint('h80);
    send_codepoint('h7ff);
    send_codepoint('h800);
    send_codepoint('hffff);
    send_codepoint('h10000);
    send_codepoint('h10ffff);
    send_byte(jsu_pkg::ChrQuote);
    // Malformed escapes and early ends of text.
    send_text("\\u12G");
    send_hex(16'hdfff, 4);
    send_hex(16'hdbff, 4);
    send_byte(jsu_pkg::ChrQuote);
    send_hex(16'hd800, 4);
    send_text("\\x");
    send_hex(16'hd800, 4);
    send_hex(16'h0041, 4);
    send_hex(16'hd800, 4);
    send_text("\\u0G");
    send_hex(16'hd800, 4);
    send_hex(16'h0000, 2);
    send_byte(jsu_pkg::ChrNul);
    send_hex(16'hd800, 4);
    send_byte(jsu_pkg::ChrNul);
    send_hex(16'hd800, 4);
    send_byte(jsu_pkg::ChrBslash);
    send_byte(jsu_pkg::ChrNul);
    send_hex(16'h0000, 1);
    send_byte(jsu_pkg::ChrNul);
    send_byte(jsu_pkg::ChrBslash);
    send_byte(jsu_pkg::ChrNul);
    send_byte(jsu_pkg::ChrNul);
    wait_drained();

    start = bytes_sent;
    while (bytes_sent - start < RandomItems) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 11) == 0) wait_drained();
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            do b = 8'($urandom_range(1, 255));
            while (b == jsu_pkg::ChrQuote || b == jsu_pkg::ChrBslash);
            send_byte(b);
          end
          5, 6: begin
            send_byte(jsu_pkg::ChrBslash);
            send_byte(esc_chars[$urandom_range(0, 7)]);
          end
          7, 8: begin
            case ($urandom_range(0, 3))
              0: cp = $urandom_range(0, 'h7f);
              1: cp = $urandom_range('h80, 'h7ff);
              2: do cp = $urandom_range('h800, 'hffff); while (cp >= 'hd800 && cp < 'he000);
              default: cp = $urandom_range('h10000, 'h10ffff);
            endcase
            send_codepoint(cp);
          end
          default: begin
            do b = 8'($urandom_range(1, 255));
            while (b inside {jsu_pkg::ChrBslash, jsu_pkg::ChrSlash, jsu_pkg::ChrQuote,
                             jsu_pkg::ChrB, jsu_pkg::ChrF, jsu_pkg::ChrN, jsu_pkg::ChrR,
                             jsu_pkg::ChrT, jsu_pkg::ChrU});
            send_byte(jsu_pkg::ChrBslash);
            send_byte(b);
          end
        endcase
      end

      u = 16'hd800 | 16'($urandom_range(0, 1023));
      if ($urandom_range(0, 9) < 7) begin
        send_byte(jsu_pkg::ChrQuote);
      end else begin
        case ($urandom_range(0, 8))
          0: send_byte(jsu_pkg::ChrNul);
          1: begin
            send_byte(jsu_pkg::ChrBslash);
            send_byte(jsu_pkg::ChrNul);
          end
          2: begin
            send_hex(16'($urandom), $urandom_range(0, 3));
            send_byte(bad_digit());
          end
          3: send_hex(16'hdc00 | 16'($urandom_range(0, 1023)), 4);
          4: begin
            send_hex(u, 4);
            send_byte(random_except(jsu_pkg::ChrBslash));
          end
          5: begin
            send_hex(u, 4);
            send_byte(jsu_pkg::ChrBslash);
            send_byte(random_except(jsu_pkg::ChrU));
          end
          6: begin
            send_hex(u, 4);
            send_hex(16'($urandom), $urandom_range(0, 3));
            send_byte(bad_digit());
          end
          7: begin
            send_hex(u, 4);
            do u = 16'($urandom); while ((u & 16'hfc00) == 16'hdc00);
            send_hex(u, 4);
          end
          default: begin
            // Noise that is rich in escape characters and hex digits.
            repeat ($urandom_range(1, 8)) begin
              case ($urandom_range(0, 3))
                0: send_byte(8'($urandom_range(0, 255)));
                1: send_byte(jsu_pkg::ChrBslash);
                2: send_byte(jsu_pkg::ChrU);
                default: send_byte(8'h41 + 8'($urandom_range(0, 5)));
              endcase
            end
          end
        endcase
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
